// ===== hdl/prl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and operation codes for the positional record list.
package prl_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = ((LEN_W > 6) ? LEN_W : 6) + 1;

    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_UPDATE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [5:0]  position;
        logic [63:0] name_head;
        logic [7:0]  name_tail;
        logic [7:0]  age_value;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [63:0] read_name_head;
        logic [7:0]  read_name_tail;
        logic [7:0]  read_age;
        logic [5:0]  entry_count;
    } t_result;

    typedef struct packed {
        logic [63:0] name_head;
        logic [7:0]  name_tail;
        logic [7:0]  age;
    } t_entry;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic             upd;
        logic [CMP_W-1:0] slot;
    } t_cell_ctl;

endpackage

// ===== hdl/prl_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list: holds a record and loads from a neighbour or the new word.
module prl_cell (
    input  logic                    i_clk,
    input  logic [prl_pkg::IDX_W-1:0] i_slot,
    input  prl_pkg::t_cell_ctl      i_ctl,
    input  prl_pkg::t_entry         i_new,
    input  prl_pkg::t_entry         i_prev,
    input  prl_pkg::t_entry         i_next,
    output prl_pkg::t_entry         o_entry
);
    import prl_pkg::*;

    t_entry           r_entry;
    t_entry           n_entry;
    logic [CMP_W-1:0] slot_w;

    assign slot_w = CMP_W'(i_slot);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (slot_w == i_ctl.slot) begin
                n_entry = i_new;
            end else if (slot_w > i_ctl.slot) begin
                n_entry = i_prev;
            end
        end else if (i_ctl.del) begin
            if (slot_w >= i_ctl.slot) begin
                n_entry = i_next;
            end
        end else if (i_ctl.upd) begin
            if (slot_w == i_ctl.slot) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/positional_record_list_core.sv =====
`timescale 1ns / 1ps
// Top level of the positional record list: command decode, cell chain and result register.
// Each command word is taken when start is high and busy is never raised, so a new
// command may be issued on every cycle. The result word appears on o_result, marked by
// o_strobe, in the cycle after the command is accepted. Insert and delete move each stored
// record at or after the given position one cell along the chain in that same cycle; the
// receiver cannot hold results off and must take each word as it is shown.
module positional_record_list_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  prl_pkg::t_cmd     i_cmd,
    output logic              o_strobe,
    output prl_pkg::t_result  o_result
);
    import prl_pkg::*;

    logic [LEN_W-1:0] r_length;
    logic [LEN_W-1:0] n_length;
    logic             r_strobe;
    t_result          r_result;
    t_result          n_result;
    t_cell_ctl        ctl;
    t_entry           new_entry;
    t_entry           cell_q [MAX_ENTRIES];
    t_entry           rd_data;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] len_w;
    logic [CMP_W-1:0] cnt_w;
    logic             accept;
    logic             is_full;
    logic             in_list;
    logic             ins_ok;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_w   = CMP_W'(i_cmd.position);
    assign len_w   = CMP_W'(r_length);
    assign is_full = (len_w >= CMP_W'(MAX_ENTRIES));
    assign in_list = (pos_w != '0) && (pos_w <= len_w);
    assign ins_ok  = (pos_w != '0) && (pos_w <= len_w + CMP_W'(1));

    assign new_entry.name_head = i_cmd.name_head;
    assign new_entry.name_tail = i_cmd.name_tail;
    assign new_entry.age       = i_cmd.age_value;

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (CMP_W'(k + 1) == pos_w) begin
                rd_data = rd_data | cell_q[k];
            end
        end
    end

    always_comb begin
        ctl.ins  = 1'b0;
        ctl.del  = 1'b0;
        ctl.upd  = 1'b0;
        ctl.slot = pos_w - CMP_W'(1);
        n_length = r_length;
        n_result = '0;
        n_result.status = STATUS_DONE;
        case (i_cmd.func)
            FUNC_INSERT: begin
                if (is_full) begin
                    n_result.status = STATUS_FULL;
                end else if (!ins_ok) begin
                    n_result.status = STATUS_RANGE;
                end else begin
                    ctl.ins  = accept;
                    n_length = r_length + LEN_W'(1);
                end
            end
            FUNC_DELETE: begin
                if (!in_list) begin
                    n_result.status = STATUS_RANGE;
                end else begin
                    ctl.del  = accept;
                    n_length = r_length - LEN_W'(1);
                end
            end
            FUNC_UPDATE: begin
                if (!in_list) begin
                    n_result.status = STATUS_RANGE;
                end else begin
                    ctl.upd = accept;
                end
            end
            FUNC_READ: begin
                if (!in_list) begin
                    n_result.status = STATUS_RANGE;
                end else begin
                    n_result.read_name_head = rd_data.name_head;
                    n_result.read_name_tail = rd_data.name_tail;
                    n_result.read_age       = rd_data.age;
                end
            end
            default: begin
                n_result.status = STATUS_RANGE;
            end
        endcase
        cnt_w = CMP_W'(n_length);
        n_result.entry_count = cnt_w[5:0];
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            t_entry prev_q;
            t_entry next_q;
            if (g == 0) begin : g_first
                assign prev_q = '0;
            end else begin : g_mid_prev
                assign prev_q = cell_q[g-1];
            end
            if (g == MAX_ENTRIES - 1) begin : g_last
                assign next_q = '0;
            end else begin : g_mid_next
                assign next_q = cell_q[g+1];
            end
            prl_cell u_cell (
                .i_clk   (i_clk),
                .i_slot  (IDX_W'(g)),
                .i_ctl   (ctl),
                .i_new   (new_entry),
                .i_prev  (prev_q),
                .i_next  (next_q),
                .o_entry (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (accept) begin
                r_length <= n_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
